// ===== sv/qphh_pkg.sv =====
`timescale 1ns / 1ps
package qphh_pkg;

  // input item kinds
  localparam logic [1:0] KIND_EVENT    = 2'd0;
  localparam logic [1:0] KIND_READ     = 2'd1;
  localparam logic [1:0] KIND_READ_CLR = 2'd2;

  // configuration register indexes
  localparam logic [2:0] REG_REQUIRED_PARTICLE = 3'd0;
  localparam logic [2:0] REG_CHECK_WIRE_CODES  = 3'd1;
  localparam logic [2:0] REG_WIRE_CODE_LIMIT   = 3'd2;
  localparam logic [2:0] REG_RADIUS_SQ_LIMIT   = 3'd3;
  localparam logic [2:0] REG_RANGE_LOW         = 3'd4;
  localparam logic [2:0] REG_BIN_WIDTH         = 3'd5;
  localparam logic [2:0] REG_BINS_IN_USE       = 3'd6;

  localparam int CFG_DATA_W = 24;
  localparam int DIV_STEPS  = 8;   // quotient bits; bins per channel stay below 256

  typedef struct packed {
    logic [1:0]         kind;
    logic [2:0]         particle_id;
    logic [1:0]         event_type;
    logic [1:0]         side;
    logic               energy_positive;
    logic signed [11:0] x_east;
    logic signed [11:0] y_east;
    logic signed [11:0] x_west;
    logic signed [11:0] y_west;
    logic [15:0]        wire_info;
    logic [63:0]        pmt_energies;
    logic [9:0]         read_address;
  } in_item_t;

  typedef struct packed {
    logic        accepted;
    logic [3:0]  counted_mask;
    logic [31:0] bin_count;
  } out_result_t;

  typedef struct packed {
    logic [2:0]         required_particle;
    logic               check_wire_codes;
    logic [3:0]         wire_code_limit;
    logic [23:0]        radius_sq_limit;
    logic signed [15:0] range_low;
    logic [14:0]        bin_width;
    logic [7:0]         bins_in_use;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    required_particle: 3'd1,
    check_wire_codes:  1'b1,
    wire_code_limit:   4'd6,
    radius_sq_limit:   24'd230400,
    range_low:         16'sd0,
    bin_width:         15'd10,
    bins_in_use:       8'd100
  };

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SQ,
    ST_QUAL,
    ST_DIV,
    ST_UPD,
    ST_RDATA
  } st_t;

endpackage

// ===== sv/qualified_pulse_height_histogram_top.sv =====
`timescale 1ns / 1ps
// Channel   Ports                                   Handshake
// input     start, busy, in_item                    taken when start && !busy
// result    out_valid, out_result                   one-cycle strobe, no back-pressure
// config    cfg_we, cfg_index, cfg_data             written when cfg_we
//
// An event passes the filter, the four bit-serial bin dividers running side by side,
// the memory read-modify-write of up to four counts and the result register before
// its result strobe; a rejected event is answered from the filter through the result
// register.
// A read or read-and-clear waits on the registered memory read; an unused kind is answered straight from idle.
// After reset the count memory is swept to zero with busy high.
// The receiver cannot stall; one item is in work at a time.
module qualified_pulse_height_histogram_top import qphh_pkg::*; #(
  parameter int MAX_BINS = 128,
  parameter int CHANNELS = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  in_item_t              in_item,
  output logic                  out_valid,
  output out_result_t           out_result,
  input  logic                  cfg_we,
  input  logic [2:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int DEPTH = CHANNELS * MAX_BINS;
  localparam int AW    = $clog2(DEPTH);

  st_t               state_r, state_nxt;
  cfg_t              cfg_r;
  in_item_t          item_r, item_nxt;
  logic [AW-1:0]     clr_addr_r, clr_addr_nxt;
  logic [22:0]       lim_r, lim_nxt;
  logic [3:0][15:0]  rem_r, rem_nxt;
  logic [3:0][7:0]   quo_r, quo_nxt;
  logic [3:0]        mask_r, mask_nxt;
  logic [21:0]       dsr_r, dsr_nxt;
  logic [2:0]        div_cnt_r, div_cnt_nxt;
  logic [2:0]        upd_cnt_r, upd_cnt_nxt;
  logic              wr_pend_r, wr_pend_nxt;
  logic [AW-1:0]     wr_addr_r, wr_addr_nxt;
  logic              rd_hit_r, rd_hit_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_result_t       out_result_r, out_result_nxt;
  logic [31:0]       rd_data_r;

  logic [31:0]       mem [DEPTH];
  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_wa, mem_ra;
  logic [31:0]       mem_wd;

  logic              cut_ok;

  function automatic logic [AW-1:0] lane_addr(input logic s, input logic [1:0] t,
                                              input logic [7:0] q);
    lane_addr = AW'({s, t}) * AW'(MAX_BINS) + AW'(q);
  endfunction

  qphh_cut u_cut (
    .clk  (clk),
    .item (item_r),
    .cfg  (cfg_r),
    .ok   (cut_ok)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_REQUIRED_PARTICLE: cfg_r.required_particle <= cfg_data[2:0];
        REG_CHECK_WIRE_CODES:  cfg_r.check_wire_codes  <= cfg_data[0];
        REG_WIRE_CODE_LIMIT:   cfg_r.wire_code_limit   <= cfg_data[3:0];
        REG_RADIUS_SQ_LIMIT:   cfg_r.radius_sq_limit   <= cfg_data[23:0];
        REG_RANGE_LOW:         cfg_r.range_low         <= cfg_data[15:0];
        REG_BIN_WIDTH:         cfg_r.bin_width         <= cfg_data[14:0];
        REG_BINS_IN_USE:       cfg_r.bins_in_use       <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      wr_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      wr_pend_r   <= wr_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r       <= item_nxt;
    lim_r        <= lim_nxt;
    rem_r        <= rem_nxt;
    quo_r        <= quo_nxt;
    mask_r       <= mask_nxt;
    dsr_r        <= dsr_nxt;
    div_cnt_r    <= div_cnt_nxt;
    upd_cnt_r    <= upd_cnt_nxt;
    wr_addr_r    <= wr_addr_nxt;
    rd_hit_r     <= rd_hit_nxt;
    out_result_r <= out_result_nxt;
  end

  // count memory
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (mem_re) rd_data_r <= mem[mem_ra];
  end

  always_comb begin
    logic [7:0]         nb;
    logic signed [15:0] e;
    logic [16:0]        diff;
    logic [3:0]         lane_ok;
    logic [1:0]         lane;

    state_nxt      = state_r;
    item_nxt       = item_r;
    clr_addr_nxt   = clr_addr_r;
    lim_nxt        = lim_r;
    rem_nxt        = rem_r;
    quo_nxt        = quo_r;
    mask_nxt       = mask_r;
    dsr_nxt        = dsr_r;
    div_cnt_nxt    = div_cnt_r;
    upd_cnt_nxt    = upd_cnt_r;
    wr_pend_nxt    = 1'b0;
    wr_addr_nxt    = wr_addr_r;
    rd_hit_nxt     = rd_hit_r;
    out_valid_nxt  = 1'b0;
    out_result_nxt = out_result_r;
    mem_we         = 1'b0;
    mem_wa         = wr_addr_r;
    mem_wd         = '0;
    mem_re         = 1'b0;
    mem_ra         = AW'(in_item.read_address);
    lane_ok        = '0;
    lane           = upd_cnt_r[1:0];
    e              = '0;
    diff           = '0;
    nb = (int'(cfg_r.bins_in_use) > MAX_BINS) ? 8'(MAX_BINS) : cfg_r.bins_in_use;

    unique case (state_r)
      ST_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_addr_r;
        if (clr_addr_r == AW'(DEPTH - 1)) state_nxt = ST_IDLE;
        else clr_addr_nxt = clr_addr_r + AW'(1);
      end
      ST_IDLE: begin
        if (start) begin
          item_nxt = in_item;
          unique case (in_item.kind) inside
            KIND_EVENT: state_nxt = ST_SQ;
            KIND_READ, KIND_READ_CLR: begin
              rd_hit_nxt = int'(in_item.read_address) < DEPTH;
              mem_re     = rd_hit_nxt;
              state_nxt  = ST_RDATA;
            end
            default: begin
              out_valid_nxt  = 1'b1;
              out_result_nxt = '0;
            end
          endcase
        end
      end
      ST_SQ: begin
        // nb * width bounds the binned span; zero width or zero bins bins nothing
        lim_nxt   = {15'd0, nb} * {8'd0, cfg_r.bin_width};
        state_nxt = ST_QUAL;
      end
      ST_QUAL: begin
        for (int t = 0; t < 4; t++) begin
          e    = item_r.pmt_energies[16*t +: 16];
          diff = {e[15], e} - {cfg_r.range_low[15], cfg_r.range_low};
          lane_ok[t] = !diff[16] && ({7'd0, diff[15:0]} < lim_r) &&
                       (int'({item_r.side[0], 2'(t)}) < CHANNELS);
          rem_nxt[t] = diff[15:0];
          quo_nxt[t] = '0;
        end
        mask_nxt = cut_ok ? lane_ok : 4'd0;
        if (!cut_ok) begin
          out_valid_nxt  = 1'b1;
          out_result_nxt = '0;
          state_nxt      = ST_IDLE;
        end else begin
          dsr_nxt     = {cfg_r.bin_width, 7'd0};
          div_cnt_nxt = 3'(DIV_STEPS - 1);
          state_nxt   = ST_DIV;
        end
      end
      ST_DIV: begin
        // restoring division, one quotient bit per cycle in every lane
        for (int t = 0; t < 4; t++) begin
          if ({6'd0, rem_r[t]} >= dsr_r) begin
            rem_nxt[t] = rem_r[t] - dsr_r[15:0];
            quo_nxt[t] = {quo_r[t][6:0], 1'b1};
          end else begin
            quo_nxt[t] = {quo_r[t][6:0], 1'b0};
          end
        end
        dsr_nxt = dsr_r >> 1;
        if (div_cnt_r == 3'd0) begin
          upd_cnt_nxt = '0;
          state_nxt   = ST_UPD;
        end else begin
          div_cnt_nxt = div_cnt_r - 3'd1;
        end
      end
      ST_UPD: begin
        // lanes hit distinct tubes, so read of lane n overlaps write of lane n-1
        if (wr_pend_r) begin
          mem_we = 1'b1;
          mem_wa = wr_addr_r;
          mem_wd = (rd_data_r == '1) ? rd_data_r : rd_data_r + 32'd1;
        end
        if (upd_cnt_r == 3'd4) begin
          out_valid_nxt                = 1'b1;
          out_result_nxt.accepted      = 1'b1;
          out_result_nxt.counted_mask  = mask_r;
          out_result_nxt.bin_count     = '0;
          state_nxt                    = ST_IDLE;
        end else begin
          mem_ra      = lane_addr(item_r.side[0], lane, quo_r[lane]);
          mem_re      = mask_r[lane];
          wr_pend_nxt = mask_r[lane];
          wr_addr_nxt = mem_ra;
          upd_cnt_nxt = upd_cnt_r + 3'd1;
        end
      end
      ST_RDATA: begin
        out_valid_nxt                = 1'b1;
        out_result_nxt.accepted      = 1'b0;
        out_result_nxt.counted_mask  = '0;
        out_result_nxt.bin_count     = rd_hit_r ? rd_data_r : 32'd0;
        if (rd_hit_r && (item_r.kind == KIND_READ_CLR)) begin
          mem_we = 1'b1;
          mem_wa = AW'(item_r.read_address);
        end
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign busy       = (state_r != ST_IDLE);
  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;

`ifndef SYNTHESIS
  a_wr_only_in_upd: assert property (@(posedge clk) disable iff (!rst_n)
    wr_pend_r |-> (state_r == ST_UPD))
    else $error("count write pending outside update");

  a_dsr_shift: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |=> (dsr_r == ($past(dsr_r) >> 1)))
    else $error("divisor not halved during division");

  a_mask_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_result_r.counted_mask != 4'd0)) |->
      (out_result_r.accepted && (out_result_r.bin_count == 32'd0)))
    else $error("counted mask on a non-accepted result");

  a_item_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (out_valid_r || busy))
    else $error("accepted item neither answered nor in work");
`endif

endmodule

// ===== sv/qphh_cut.sv =====
`timescale 1ns / 1ps
// Event filter: squares and simple cuts registered, radius compare after.
module qphh_cut import qphh_pkg::*; (
  input  logic     clk,
  input  in_item_t item,
  input  cfg_t     cfg,
  output logic     ok
);

  logic signed [23:0] p_xe, p_ye, p_xw, p_yw;
  logic [22:0]        sq_xe_r, sq_ye_r, sq_xw_r, sq_yw_r;
  logic               basic_r;
  logic [23:0]        rsq_e, rsq_w;
  logic [3:0]         x_code, y_code, x_mult, y_mult;
  logic               basic;

  always_comb begin
    p_xe = item.x_east * item.x_east;
    p_ye = item.y_east * item.y_east;
    p_xw = item.x_west * item.x_west;
    p_yw = item.y_west * item.y_west;
    x_code = item.wire_info[3:0];
    y_code = item.wire_info[7:4];
    x_mult = item.wire_info[11:8];
    y_mult = item.wire_info[15:12];
    basic = (item.particle_id == cfg.required_particle) && !item.side[1] &&
            (item.event_type == 2'd0) && item.energy_positive &&
            (!cfg.check_wire_codes ||
             ((x_code <= cfg.wire_code_limit) && (y_code <= cfg.wire_code_limit))) &&
            (x_mult != 4'd0) && (y_mult != 4'd0);
  end

  always_ff @(posedge clk) begin
    sq_xe_r <= p_xe[22:0];
    sq_ye_r <= p_ye[22:0];
    sq_xw_r <= p_xw[22:0];
    sq_yw_r <= p_yw[22:0];
    basic_r <= basic;
  end

  assign rsq_e = {1'b0, sq_xe_r} + {1'b0, sq_ye_r};
  assign rsq_w = {1'b0, sq_xw_r} + {1'b0, sq_yw_r};
  assign ok    = basic_r && (rsq_e <= cfg.radius_sq_limit) &&
                 (rsq_w <= cfg.radius_sq_limit);

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
  import qphh_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;

  // Shadow of the histogram: filter, binning and count store, plus the queue of
  // results still owed by the block.
  class spectrum_tracker;
    localparam int NCHAN  = 8;
    localparam int NSLOTS = 128;

    cfg_t        shadow_cfg;
    logic [31:0] shadow_counts [NCHAN*NSLOTS];
    out_result_t expected_readouts [$];
    int          mismatches;

    function new();
      shadow_cfg = CFG_RESET;
      foreach (shadow_counts[i]) shadow_counts[i] = '0;
      mismatches = 0;
    endfunction

    function int radius_sq(logic [11:0] x, logic [11:0] y);
      int xs, ys;
      xs = $signed(x);
      ys = $signed(y);
      return xs * xs + ys * ys;
    endfunction

    function void write_reg(logic [2:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_REQUIRED_PARTICLE: shadow_cfg.required_particle = val[2:0];
        REG_CHECK_WIRE_CODES:  shadow_cfg.check_wire_codes  = val[0];
        REG_WIRE_CODE_LIMIT:   shadow_cfg.wire_code_limit   = val[3:0];
        REG_RADIUS_SQ_LIMIT:   shadow_cfg.radius_sq_limit   = val[23:0];
        REG_RANGE_LOW:         shadow_cfg.range_low         = val[15:0];
        REG_BIN_WIDTH:         shadow_cfg.bin_width         = val[14:0];
        REG_BINS_IN_USE:       shadow_cfg.bins_in_use       = val[7:0];
        default: ;
      endcase
    endfunction

    function int waiting();
      return expected_readouts.size();
    endfunction

    function void note_item(in_item_t it);
      out_result_t r;
      logic        ok;
      logic [3:0]  xc, yc, xm, ym;
      int          nb, w, lo, e, slot, ch, addr, rlim;
      r = '0;
      case (it.kind)
        KIND_EVENT: begin
          {ym, xm, yc, xc} = it.wire_info;
          rlim = shadow_cfg.radius_sq_limit;
          ok = it.particle_id == shadow_cfg.required_particle && it.side < 2'd2 &&
               it.event_type == 2'd0 && it.energy_positive;
          if (ok && shadow_cfg.check_wire_codes &&
              (xc > shadow_cfg.wire_code_limit || yc > shadow_cfg.wire_code_limit))
            ok = 1'b0;
          if (ok && (xm == 4'd0 || ym == 4'd0))
            ok = 1'b0;
          if (ok && (radius_sq(it.x_east, it.y_east) > rlim ||
                     radius_sq(it.x_west, it.y_west) > rlim))
            ok = 1'b0;
          if (ok) begin
            r.accepted = 1'b1;
            nb = shadow_cfg.bins_in_use;
            if (nb > NSLOTS) nb = NSLOTS;
            w  = shadow_cfg.bin_width;
            lo = $signed(shadow_cfg.range_low);
            for (int t = 0; t < 4; t++) begin
              e  = $signed(it.pmt_energies[16*t +: 16]);
              ch = int'(it.side) * 4 + t;
              if (w != 0 && e >= lo && ch < NCHAN) begin
                slot = (e - lo) / w;
                if (slot < nb) begin
                  addr = ch * NSLOTS + slot;
                  // counts saturate at all ones
                  if (shadow_counts[addr] != '1)
                    shadow_counts[addr] = shadow_counts[addr] + 32'd1;
                  r.counted_mask[t] = 1'b1;
                end
              end
            end
          end
        end
        KIND_READ, KIND_READ_CLR: begin
          addr = it.read_address;
          if (addr < NCHAN * NSLOTS) begin
            r.bin_count = shadow_counts[addr];
            if (it.kind == KIND_READ_CLR) shadow_counts[addr] = '0;
          end
        end
        default: ;
      endcase
      expected_readouts.insert(expected_readouts.size(), r);
    endfunction

    function void check_result(out_result_t got);
      out_result_t want;
      if (expected_readouts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with none expected: accepted %0b mask %h count %0d",
                   $time, got.accepted, got.counted_mask, got.bin_count);
        return;
      end
      want = expected_readouts.pop_front();
      if (got.accepted !== want.accepted || got.counted_mask !== want.counted_mask ||
          got.bin_count !== want.bin_count) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: mismatch (exp/got) accepted %0b/%0b mask %h/%h count %0d/%0d",
                   $time, want.accepted, got.accepted, want.counted_mask,
                   got.counted_mask, want.bin_count, got.bin_count);
      end
    endfunction
  endclass

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  start     = 1'b0;
  logic                  busy;
  in_item_t              in_item   = '0;
  logic                  out_valid;
  out_result_t           out_result;
  logic                  cfg_we    = 1'b0;
  logic [2:0]            cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  quiet     = 1'b0;

  spectrum_tracker sb;

  qualified_pulse_height_histogram_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_result (out_result),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid !== 1'b0) sb.check_result(out_result);
  end

  function automatic in_item_t make_noise();
    in_item_t it;
    for (int b = 0; b < $bits(in_item_t); b++) it[b] = 1'($urandom_range(0, 1));
    return it;
  endfunction

  // chamber position inside the current radius cut, falling back to the centre
  function automatic void pick_xy(output logic [11:0] px, output logic [11:0] py);
    int span, xi, yi;
    case ($urandom_range(0, 2))
      0:       span = 64;
      1:       span = 512;
      default: span = 2048;
    endcase
    px = '0;
    py = '0;
    for (int k = 0; k < 8; k++) begin
      xi = int'($urandom_range(0, 2 * span - 1)) - span;
      yi = int'($urandom_range(0, 2 * span - 1)) - span;
      if (sb.radius_sq(12'(xi), 12'(yi)) <= int'(sb.shadow_cfg.radius_sq_limit)) begin
        px = 12'(xi);
        py = 12'(yi);
        break;
      end
    end
  endfunction

  // mostly around the binned range, a bin either side, sometimes anything
  function automatic logic [15:0] pick_energy();
    int w, nb, lo, e;
    w  = sb.shadow_cfg.bin_width;
    nb = sb.shadow_cfg.bins_in_use;
    lo = $signed(sb.shadow_cfg.range_low);
    if (w == 0) w = 10;
    if (nb > 128) nb = 128;
    if (nb == 0) nb = 4;
    if ($urandom_range(0, 99) < 15) return 16'($urandom);
    e = lo - w + int'($urandom_range(0, (nb + 2) * w - 1));
    if (e > 32767) e = 32767;
    if (e < -32768) e = -32768;
    return 16'(e);
  endfunction

  function automatic in_item_t make_event(input logic broken);
    in_item_t    it;
    logic [3:0]  xc, yc, xm, ym, lim;
    logic [11:0] ex, ey, wx, wy;
    it = make_noise();
    it.kind            = KIND_EVENT;
    it.particle_id     = sb.shadow_cfg.required_particle;
    it.event_type      = 2'd0;
    it.side            = 2'($urandom_range(0, 1));
    it.energy_positive = 1'b1;
    lim = sb.shadow_cfg.check_wire_codes ? sb.shadow_cfg.wire_code_limit : 4'd15;
    xc = 4'($urandom_range(0, lim));
    yc = 4'($urandom_range(0, lim));
    xm = 4'($urandom_range(1, 15));
    ym = 4'($urandom_range(1, 15));
    pick_xy(ex, ey);
    pick_xy(wx, wy);
    for (int t = 0; t < 4; t++) it.pmt_energies[16*t +: 16] = pick_energy();
    if (broken) begin
      case ($urandom_range(0, 8))
        0: it.particle_id = it.particle_id + 3'($urandom_range(1, 7));
        1: it.side = 2'($urandom_range(2, 3));
        2: it.event_type = 2'($urandom_range(1, 3));
        3: it.energy_positive = 1'b0;
        4: xc = (lim == 4'd15) ? lim : 4'($urandom_range(lim + 1, 15));
        5: yc = (lim == 4'd15) ? lim : 4'($urandom_range(lim + 1, 15));
        6: if ($urandom_range(0, 1)) xm = '0; else ym = '0;
        7: begin
          ex = 12'($urandom);
          ey = 12'($urandom);
        end
        default: begin
          wx = 12'($urandom);
          wy = 12'($urandom);
        end
      endcase
    end
    it.wire_info = {ym, xm, yc, xc};
    it.x_east = ex;
    it.y_east = ey;
    it.x_west = wx;
    it.y_west = wy;
    return it;
  endfunction

  function automatic in_item_t make_read();
    in_item_t it;
    int       nb;
    it = make_noise();
    it.kind = ($urandom_range(0, 99) < 30) ? KIND_READ_CLR : KIND_READ;
    nb = sb.shadow_cfg.bins_in_use;
    if (nb > 128) nb = 128;
    if (nb == 0) nb = 1;
    // aim most reads at bins that can hold counts
    if ($urandom_range(0, 99) < 85)
      it.read_address = 10'($urandom_range(0, 7) * 128 + $urandom_range(0, nb - 1));
    return it;
  endfunction

  function automatic in_item_t base_event();
    in_item_t it;
    it = '0;
    it.kind            = KIND_EVENT;
    it.particle_id     = CFG_RESET.required_particle;
    it.energy_positive = 1'b1;
    it.wire_info       = 16'h1111;
    it.pmt_energies    = {16'hFFFF, 16'd1000, 16'd999, 16'd0};
    return it;
  endfunction

  function automatic cfg_t random_cfg();
    cfg_t c;
    c.required_particle = 3'($urandom);
    c.check_wire_codes  = 1'($urandom);
    c.wire_code_limit   = 4'($urandom_range(2, 15));
    c.radius_sq_limit   = 24'($urandom_range(20000, 8388608));
    c.range_low         = 16'(int'($urandom_range(0, 4000)) - 2000);
    c.bin_width         = ($urandom_range(0, 9) == 0) ? 15'($urandom_range(1, 32767))
                                                      : 15'($urandom_range(1, 40));
    c.bins_in_use       = 8'($urandom_range(1, 255));
    return c;
  endfunction

  task automatic drive_item(input in_item_t it);
    int gap;
    if (!quiet && $urandom_range(0, 99) < 22) begin
      start <= 1'b0;
      gap = $urandom_range(1, 20);
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy !== 1'b0);
    sb.note_item(it);
  endtask

  // hold the sender off until every owed result is in, then let the block go quiet
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (sb.waiting() != 0) @(posedge clk);
    repeat (24) @(posedge clk);
  endtask

  task automatic apply_cfg(input cfg_t c);
    logic [CFG_DATA_W-1:0] val;
    for (int r = REG_REQUIRED_PARTICLE; r <= REG_BINS_IN_USE; r++) begin
      case (3'(r))
        REG_REQUIRED_PARTICLE: val = CFG_DATA_W'(c.required_particle);
        REG_CHECK_WIRE_CODES:  val = CFG_DATA_W'(c.check_wire_codes);
        REG_WIRE_CODE_LIMIT:   val = CFG_DATA_W'(c.wire_code_limit);
        REG_RADIUS_SQ_LIMIT:   val = CFG_DATA_W'(c.radius_sq_limit);
        REG_RANGE_LOW:         val = CFG_DATA_W'(c.range_low);
        REG_BIN_WIDTH:         val = CFG_DATA_W'(c.bin_width);
        REG_BINS_IN_USE:       val = CFG_DATA_W'(c.bins_in_use);
        default:               val = '0;
      endcase
      cfg_we    <= 1'b1;
      cfg_index <= 3'(r);
      cfg_data  <= val;
      sb.write_reg(3'(r), val);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  initial begin
    cfg_t     c;
    in_item_t d;
    int       pick;
    sb = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    // store is swept after reset
    do @(posedge clk); while (busy !== 1'b0);

    for (int k = 0; k < 21; k++) begin
      d = base_event();
      case (k)
        1: begin
          d.side         = 2'd1;
          d.wire_info    = 16'h1166;
          d.x_east       = 12'd480;
          d.x_west       = 12'(-480);
          d.pmt_energies = {16'h7FFF, 16'h8000, 16'd5, 16'd9};
        end
        2:  d.particle_id = 3'd0;
        3:  d.particle_id = 3'd7;
        4:  d.side = 2'd2;
        5:  d.side = 2'd3;
        6:  d.event_type = 2'd3;
        7:  d.energy_positive = 1'b0;
        8:  d.wire_info = 16'h1117;
        9:  d.wire_info = 16'h11F1;
        10: d.wire_info = 16'h1011;
        11: d.wire_info = 16'h0111;
        12: d.x_east = 12'd481;
        13: begin
          d.side   = 2'd1;
          d.x_west = 12'h800;
          d.y_west = 12'h800;
        end
        14: begin
          d.kind = KIND_READ;
          d.read_address = 10'd0;
        end
        15: begin
          d.kind = KIND_READ_CLR;
          d.read_address = 10'd0;
        end
        16: begin
          d.kind = KIND_READ;
          d.read_address = 10'd0;
        end
        17: begin
          d.kind = KIND_READ;
          d.read_address = 10'd227;
        end
        18: begin
          d.kind = KIND_READ_CLR;
          d.read_address = 10'd512;
        end
        19: begin
          d.kind = KIND_READ;
          d.read_address = 10'd1023;
        end
        20: d = '1;
        default: ;
      endcase
      drive_item(d);
    end
    settle();

    for (int p = 0; p < 10; p++) begin
      case (p)
        0: c = CFG_RESET;
        1: c = '{required_particle: 3'd0, check_wire_codes: 1'b0, wire_code_limit: 4'd0,
                 radius_sq_limit: 24'd8388608, range_low: 16'h8000, bin_width: 15'd1,
                 bins_in_use: 8'd128};
        2: c = '{required_particle: 3'd7, check_wire_codes: 1'b1, wire_code_limit: 4'd15,
                 radius_sq_limit: 24'd0, range_low: 16'h7FFF, bin_width: 15'd32767,
                 bins_in_use: 8'd255};
        // zero bin width: events still pass, nothing binned
        3: c = '{required_particle: 3'd2, check_wire_codes: 1'b1, wire_code_limit: 4'd6,
                 radius_sq_limit: 24'd1000000, range_low: -16'sd100, bin_width: 15'd0,
                 bins_in_use: 8'd60};
        4: c = '{required_particle: 3'd5, check_wire_codes: 1'b0, wire_code_limit: 4'd3,
                 radius_sq_limit: 24'd400000, range_low: 16'sd50, bin_width: 15'd7,
                 bins_in_use: 8'd0};
        default: c = random_cfg();
      endcase
      quiet = (p == 6);
      apply_cfg(c);
      repeat ((p < 5) ? 110 : 170) begin
        pick = $urandom_range(0, 99);
        if (pick < 60) d = make_event(1'b0);
        else if (pick < 75) d = make_event(1'b1);
        else if (pick < 92) d = make_read();
        else begin
          d = make_noise();
          if (pick >= 97) d.kind = KIND_UNUSED;
        end
        drive_item(d);
        if ($urandom_range(0, 199) == 0) settle();
      end
      settle();
    end

    if (sb.mismatches == 0 && sb.waiting() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

  initial begin
    #5000000;
    $display("FAIL");
    $finish;
  end

endmodule
